// ----- rtl/buddy_block_allocator_macros.svh -----
// ============================================================================
// Buddy block allocator assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ============================================================================
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property under reset
`define BBA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Antecedent implies consequent in the same cycle
`define BBA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rstn, prop, msg)
`define BBA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- rtl/bba_pkg.sv -----
// ============================================================================
// Buddy block allocator package
// Beat types, status codes and default parameter values.
// ============================================================================
package bba_pkg;

    localparam int LEVELS_DEF          = 8;
    localparam int MIN_BLOCK_BYTES_DEF = 4096;
    localparam int HLEV_W              = 4;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_SPACE     = 2'd1,
        ST_TOO_LARGE    = 2'd2,
        ST_INVALID_FREE = 2'd3
    } status_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] request_bytes;
        logic [6:0]  block_offset;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [6:0] granted_offset;
        logic [2:0] granted_level;
    } rsp_t;

endpackage

// ----- rtl/bba_ram.sv -----
// ============================================================================
// Generic RAM
// One write port, one read port with registered read data.
// ============================================================================
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bba_store.sv -----
// ============================================================================
// Buddy block allocator header store
// Per-unit link and header in RAM; written marks give reset contents.
// ============================================================================
module bba_store #(
    parameter int LEVELS = bba_pkg::LEVELS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      wr_en,
    input  logic [LEVELS-2:0]         wr_addr,
    input  logic [LEVELS-1:0]         wr_next,
    input  logic [bba_pkg::HLEV_W-1:0] wr_level,
    input  logic                      wr_free,
    input  logic                      wr_valid,
    input  logic                      rd_en,
    input  logic [LEVELS-2:0]         rd_addr,
    output logic [LEVELS-1:0]         rd_next,
    output logic [bba_pkg::HLEV_W-1:0] rd_level,
    output logic                      rd_free,
    output logic                      rd_valid
);

    localparam int UNITS = 1 << (LEVELS - 1);
    localparam int EW    = LEVELS + bba_pkg::HLEV_W + 2;

    logic [UNITS-1:0] mark_reg;
    logic             rd_mark_reg;
    logic             rd_unit0_reg;
    logic [EW-1:0]    ram_rd_data;
    logic [EW-1:0]    dflt;
    logic [EW-1:0]    entry;

    bba_ram #(
        .WIDTH (EW),
        .DEPTH (UNITS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({wr_next, wr_level, wr_free, wr_valid}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_reg     <= '0;
            rd_mark_reg  <= 1'b0;
            rd_unit0_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                mark_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_mark_reg  <= mark_reg[rd_addr];
                rd_unit0_reg <= (rd_addr == '0);
            end
        end
    end

    assign dflt = rd_unit0_reg
                ? {LEVELS'(UNITS), bba_pkg::HLEV_W'(LEVELS - 1), 1'b1, 1'b1}
                : {LEVELS'(UNITS), bba_pkg::HLEV_W'(0), 1'b0, 1'b0};
    assign entry = rd_mark_reg ? ram_rd_data : dflt;

    assign {rd_next, rd_level, rd_free, rd_valid} = entry;

endmodule

// ----- rtl/buddy_block_allocator.sv -----
// ============================================================================
// Buddy block allocator
// Allocates and frees power-of-two blocks of one pool with a small sequencer.
// ============================================================================
//  Channel  Direction  Ports                    Beat
//  s_       in         s_valid s_ready s_data   bba_pkg::req_t
//  m_       out        m_valid m_ready m_data   bba_pkg::rsp_t
//
//  Allocate: size steps (up to LEVELS), search steps (up to LEVELS) and
//  splits (up to LEVELS-1). Free: a header check, then per merge level a
//  buddy check and a walk of up to 2^(LEVELS-1) free-list entries; the header
//  RAM port and the one list walker serialise these steps. Ready only while idle;
//  a result waiting on m_ready stalls the next result, not acceptance.
//  Reset is synchronous; the pool starts as one free top block.
module buddy_block_allocator #(
    parameter int LEVELS          = bba_pkg::LEVELS_DEF,
    parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bba_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bba_pkg::rsp_t m_data
);

    `include "buddy_block_allocator_macros.svh"

    localparam int UNITS = 1 << (LEVELS - 1);
    localparam int AW    = LEVELS - 1;
    localparam int LW    = $clog2(LEVELS);
    localparam int HW    = bba_pkg::HLEV_W;
    localparam int LIM_W = 48;
    localparam logic [LW-1:0]     TOP = LW'(LEVELS - 1);
    localparam logic [LEVELS-1:0] NIL = LEVELS'(UNITS);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_SIZE     = 14'b00000000000010,
        S_SEARCH   = 14'b00000000000100,
        S_POP      = 14'b00000000001000,
        S_SPLIT    = 14'b00000000010000,
        S_FCHK     = 14'b00000000100000,
        S_BUD      = 14'b00000001000000,
        S_BUDCHK   = 14'b00000010000000,
        S_WALK     = 14'b00000100000000,
        S_WALKD    = 14'b00001000000000,
        S_MERGE_HI = 14'b00010000000000,
        S_MERGE_LO = 14'b00100000000000,
        S_PUSH     = 14'b01000000000000,
        S_RESP     = 14'b10000000000000
    } state_t;

    state_t              state_reg;
    logic [LW-1:0]       lvl_reg;
    logic [LW-1:0]       req_lvl_reg;
    logic [31:0]         bytes_reg;
    logic [AW-1:0]       blk_reg;
    logic [LEVELS-1:0]   blk_next_reg;
    logic [AW-1:0]       bud_reg;
    logic [LEVELS-1:0]   bud_next_reg;
    logic [LEVELS-1:0]   cur_reg;
    logic [LEVELS-1:0]   prev_reg;
    logic [HW-1:0]       prev_level_reg;
    logic                prev_free_reg;
    logic                prev_valid_reg;
    logic [LEVELS-1:0]   steps_reg;
    logic [LEVELS-1:0]   head_reg [LEVELS];
    bba_pkg::rsp_t       res_reg;
    logic                m_valid_reg;
    bba_pkg::rsp_t       m_data_reg;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [LEVELS-1:0]   wr_next;
    logic [HW-1:0]       wr_level;
    logic                wr_free;
    logic                wr_valid;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [LEVELS-1:0]   rd_next;
    logic [HW-1:0]       rd_level;
    logic                rd_free;
    logic                rd_valid;

    logic [LIM_W-1:0]    limit;
    logic [LW-1:0]       lvl_dn;
    logic [LW-1:0]       sat_lvl;
    logic [AW-1:0]       bud_addr;
    logic [AW-1:0]       lo_addr;
    logic [AW-1:0]       hi_addr;
    logic [LEVELS-1:0]   lo_next;
    logic                out_free;
    logic                s_acc;

    bba_store #(
        .LEVELS (LEVELS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_next  (wr_next),
        .wr_level (wr_level),
        .wr_free  (wr_free),
        .wr_valid (wr_valid),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_next  (rd_next),
        .rd_level (rd_level),
        .rd_free  (rd_free),
        .rd_valid (rd_valid)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign limit    = LIM_W'(MIN_BLOCK_BYTES) << lvl_reg;
    assign lvl_dn   = lvl_reg - 1'b1;
    assign sat_lvl  = (rd_level > HW'(LEVELS - 1)) ? TOP : LW'(rd_level);
    assign bud_addr = blk_reg ^ (AW'(1) << lvl_reg);
    assign lo_addr  = (bud_reg < blk_reg) ? bud_reg : blk_reg;
    assign hi_addr  = (bud_reg < blk_reg) ? blk_reg : bud_reg;
    assign lo_next  = (bud_reg < blk_reg) ? bud_next_reg : blk_next_reg;

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = blk_reg;
        wr_next  = NIL;
        wr_level = '0;
        wr_free  = 1'b0;
        wr_valid = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = blk_reg;
        case (state_reg)
            S_IDLE: begin
                rd_en   = s_acc && (s_data.req_type == bba_pkg::REQ_FREE);
                rd_addr = AW'(s_data.block_offset);
            end
            S_SEARCH: begin
                rd_en   = !head_reg[lvl_reg][LEVELS-1];
                rd_addr = head_reg[lvl_reg][AW-1:0];
            end
            S_POP: begin
                wr_en    = 1'b1;
                wr_level = HW'(req_lvl_reg);
                wr_valid = 1'b1;
            end
            S_SPLIT: begin
                wr_en    = (lvl_reg != req_lvl_reg);
                wr_addr  = blk_reg + (AW'(1) << lvl_dn);
                wr_next  = head_reg[lvl_dn];
                wr_level = HW'(lvl_dn);
                wr_free  = 1'b1;
                wr_valid = 1'b1;
            end
            S_FCHK: begin
                wr_en    = rd_valid && !rd_free;
                wr_next  = rd_next;
                wr_level = HW'(sat_lvl);
                wr_free  = 1'b1;
                wr_valid = 1'b1;
            end
            S_BUD: begin
                rd_en   = (lvl_reg != TOP);
                rd_addr = bud_addr;
            end
            S_WALK: begin
                if (!cur_reg[LEVELS-1] && (steps_reg != LEVELS'(UNITS))) begin
                    if (cur_reg[AW-1:0] == bud_reg) begin
                        wr_en    = !prev_reg[LEVELS-1];
                        wr_addr  = prev_reg[AW-1:0];
                        wr_next  = bud_next_reg;
                        wr_level = prev_level_reg;
                        wr_free  = prev_free_reg;
                        wr_valid = prev_valid_reg;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = cur_reg[AW-1:0];
                    end
                end
            end
            S_MERGE_HI: begin
                wr_en   = 1'b1;
                wr_addr = hi_addr;
            end
            S_MERGE_LO: begin
                wr_en    = 1'b1;
                wr_addr  = lo_addr;
                wr_next  = lo_next;
                wr_level = HW'(lvl_reg + 1'b1);
                wr_free  = 1'b1;
                wr_valid = 1'b1;
            end
            S_PUSH: begin
                wr_en    = 1'b1;
                wr_next  = head_reg[lvl_reg];
                wr_level = HW'(lvl_reg);
                wr_free  = 1'b1;
                wr_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            lvl_reg     <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= (i == LEVELS - 1) ? '0 : NIL;
            end
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_RESP)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        lvl_reg   <= '0;
                        bytes_reg <= s_data.request_bytes;
                        blk_reg   <= AW'(s_data.block_offset);
                        state_reg <= (s_data.req_type == bba_pkg::REQ_FREE) ? S_FCHK : S_SIZE;
                    end
                end
                S_SIZE: begin
                    if (LIM_W'(bytes_reg) <= limit) begin
                        req_lvl_reg <= lvl_reg;
                        state_reg   <= S_SEARCH;
                    end else if (lvl_reg == TOP) begin
                        res_reg   <= '{bba_pkg::ST_TOO_LARGE, 7'd0, 3'd0};
                        state_reg <= S_RESP;
                    end else begin
                        lvl_reg <= lvl_reg + 1'b1;
                    end
                end
                S_SEARCH: begin
                    if (!head_reg[lvl_reg][LEVELS-1]) begin
                        blk_reg   <= head_reg[lvl_reg][AW-1:0];
                        state_reg <= S_POP;
                    end else if (lvl_reg == TOP) begin
                        res_reg   <= '{bba_pkg::ST_NO_SPACE, 7'd0, 3'd0};
                        state_reg <= S_RESP;
                    end else begin
                        lvl_reg <= lvl_reg + 1'b1;
                    end
                end
                S_POP: begin
                    head_reg[lvl_reg] <= rd_next;
                    state_reg         <= S_SPLIT;
                end
                S_SPLIT: begin
                    if (lvl_reg == req_lvl_reg) begin
                        res_reg   <= '{bba_pkg::ST_OK, 7'(blk_reg), 3'(lvl_reg)};
                        state_reg <= S_RESP;
                    end else begin
                        head_reg[lvl_dn] <= LEVELS'(blk_reg + (AW'(1) << lvl_dn));
                        lvl_reg          <= lvl_dn;
                    end
                end
                S_FCHK: begin
                    if (!rd_valid || rd_free) begin
                        res_reg   <= '{bba_pkg::ST_INVALID_FREE, 7'd0, 3'd0};
                        state_reg <= S_RESP;
                    end else begin
                        lvl_reg      <= sat_lvl;
                        blk_next_reg <= rd_next;
                        state_reg    <= S_BUD;
                    end
                end
                S_BUD: begin
                    bud_reg   <= bud_addr;
                    state_reg <= (lvl_reg == TOP) ? S_PUSH : S_BUDCHK;
                end
                S_BUDCHK: begin
                    if (!rd_valid || !rd_free || (rd_level != HW'(lvl_reg))) begin
                        state_reg <= S_PUSH;
                    end else begin
                        bud_next_reg <= rd_next;
                        cur_reg      <= head_reg[lvl_reg];
                        prev_reg     <= NIL;
                        steps_reg    <= '0;
                        state_reg    <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (cur_reg[LEVELS-1] || (steps_reg == LEVELS'(UNITS))) begin
                        state_reg <= S_MERGE_HI;
                    end else if (cur_reg[AW-1:0] == bud_reg) begin
                        if (prev_reg[LEVELS-1]) begin
                            head_reg[lvl_reg] <= bud_next_reg;
                        end
                        state_reg <= S_MERGE_HI;
                    end else begin
                        state_reg <= S_WALKD;
                    end
                end
                S_WALKD: begin
                    prev_reg       <= cur_reg;
                    prev_level_reg <= rd_level;
                    prev_free_reg  <= rd_free;
                    prev_valid_reg <= rd_valid;
                    cur_reg        <= rd_next;
                    steps_reg      <= steps_reg + 1'b1;
                    state_reg      <= S_WALK;
                end
                S_MERGE_HI: begin
                    state_reg <= S_MERGE_LO;
                end
                S_MERGE_LO: begin
                    blk_reg      <= lo_addr;
                    blk_next_reg <= lo_next;
                    lvl_reg      <= lvl_reg + 1'b1;
                    state_reg    <= S_BUD;
                end
                S_PUSH: begin
                    head_reg[lvl_reg] <= LEVELS'(blk_reg);
                    res_reg           <= '{bba_pkg::ST_OK, 7'(blk_reg), 3'(lvl_reg)};
                    state_reg         <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `BBA_ASSERT(a_onehot_state, aclk, aresetn, $onehot(state_reg), "state not one-hot")
    `BBA_ASSERT(a_no_rw_clash, aclk, aresetn, !(wr_en && rd_en && (wr_addr == rd_addr)), "RAM read and write clash")
    `BBA_ASSERT(a_lvl_range, aclk, aresetn, lvl_reg <= TOP, "level beyond top")
    `BBA_ASSERT_IMPL(a_acc_busy, aclk, aresetn, s_acc, ##1 (state_reg != S_IDLE), "accepted beat left block idle")

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free requests over the request channel, predicts each
// response with an independent model of the free lists and block headers,
// and compares every response beat field by field, in order.
// ----------------------------------------------------------------------------
class alloc_scoreboard;
    localparam int LV = 8;
    localparam int NU = 128;
    localparam int NILV = NU;

    int unsigned head_q[LV];
    int unsigned next_q[NU];
    int unsigned lvl_q[NU];
    bit          is_free[NU];
    bit          is_hdr[NU];
    bba_pkg::rsp_t pending[$];
    int mismatches;
    int checked;
    int allocs_ok;
    int merges;

    function new();
        clear_pool();
        mismatches = 0;
        checked = 0;
        allocs_ok = 0;
        merges = 0;
    endfunction

    function void clear_pool();
        for (int i = 0; i < LV; i++) head_q[i] = NILV;
        for (int i = 0; i < NU; i++) begin
            next_q[i] = NILV;
            lvl_q[i] = 0;
            is_free[i] = 0;
            is_hdr[i] = 0;
        end
        lvl_q[0] = LV - 1;
        is_free[0] = 1;
        is_hdr[0] = 1;
        head_q[LV - 1] = 0;
    endfunction

    function void drop_from_list(int unsigned u, int unsigned l);
        int unsigned prv;
        int unsigned cur;
        prv = NILV;
        cur = head_q[l];
        for (int s = 0; s < NU && cur < NU; s++) begin
            if (cur == u) begin
                if (prv == NILV) head_q[l] = next_q[cur];
                else next_q[prv] = next_q[cur];
                return;
            end
            prv = cur;
            cur = next_q[cur];
        end
    endfunction

    function bba_pkg::rsp_t grant(bit [31:0] bytes);
        bba_pkg::rsp_t r;
        longint unsigned units;
        int unsigned want;
        int unsigned l;
        int unsigned blk;
        int unsigned half;
        r = '0;
        units = (longint'(bytes) + 4095) / 4096;
        want = 0;
        while (want <= LV - 1 && (64'd1 << want) < units) want++;
        if (want > LV - 1) begin
            r.status = bba_pkg::ST_TOO_LARGE;
            return r;
        end
        l = want;
        while (l <= LV - 1 && head_q[l] >= NU) l++;
        if (l > LV - 1) begin
            r.status = bba_pkg::ST_NO_SPACE;
            return r;
        end
        blk = head_q[l];
        head_q[l] = next_q[blk];
        next_q[blk] = NILV;
        is_free[blk] = 0;
        is_hdr[blk] = 1;
        while (l > want) begin
            l--;
            half = (blk + (1 << l)) % NU;
            lvl_q[half] = l;
            is_free[half] = 1;
            is_hdr[half] = 1;
            next_q[half] = head_q[l];
            head_q[l] = half;
        end
        lvl_q[blk] = want;
        allocs_ok++;
        r.status = bba_pkg::ST_OK;
        r.granted_offset = blk[6:0];
        r.granted_level = want[2:0];
        return r;
    endfunction

    function bba_pkg::rsp_t release_block(bit [6:0] off);
        bba_pkg::rsp_t r;
        int unsigned blk;
        int unsigned l;
        int unsigned bud;
        int unsigned lo;
        int unsigned hi;
        r = '0;
        blk = off % NU;
        if (!is_hdr[blk] || is_free[blk]) begin
            r.status = bba_pkg::ST_INVALID_FREE;
            return r;
        end
        l = lvl_q[blk];
        if (l > LV - 1) l = LV - 1;
        lvl_q[blk] = l;
        is_free[blk] = 1;
        is_hdr[blk] = 1;
        while (l < LV - 1) begin
            bud = (blk ^ (1 << l)) % NU;
            if (!is_hdr[bud] || !is_free[bud] || lvl_q[bud] != l) break;
            drop_from_list(bud, l);
            lo = bud < blk ? bud : blk;
            hi = bud < blk ? blk : bud;
            lvl_q[hi] = 0;
            is_free[hi] = 0;
            is_hdr[hi] = 0;
            next_q[hi] = NILV;
            blk = lo;
            l++;
            lvl_q[blk] = l;
            is_free[blk] = 1;
            is_hdr[blk] = 1;
            merges++;
        end
        next_q[blk] = head_q[l];
        head_q[l] = blk;
        r.status = bba_pkg::ST_OK;
        r.granted_offset = blk[6:0];
        r.granted_level = l[2:0];
        return r;
    endfunction

    function void note_request(bba_pkg::req_t q);
        if (q.req_type == bba_pkg::REQ_ALLOC) pending.push_back(grant(q.request_bytes));
        else pending.push_back(release_block(q.block_offset));
    endfunction

    function void check_response(bba_pkg::rsp_t got);
        bba_pkg::rsp_t want;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status || got.granted_offset !== want.granted_offset ||
            got.granted_level !== want.granted_level) begin
            mismatches++;
            if (mismatches <= 10)
                $display("response %0d: expected st=%0d off=%0d lvl=%0d, got st=%0d off=%0d lvl=%0d",
                         checked, want.status, want.granted_offset, want.granted_level,
                         got.status, got.granted_offset, got.granted_level);
        end
    endfunction

    function bit [6:0] some_live_block();
        int unsigned c;
        c = $urandom_range(NU - 1);
        for (int i = 0; i < NU; i++)
            if (is_hdr[(c + i) % NU] && !is_free[(c + i) % NU]) return 7'((c + i) % NU);
        return 7'(c);
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    bba_pkg::req_t s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    bba_pkg::rsp_t m_data;

    alloc_scoreboard board = new();
    int src_idle_pct = 19;
    int dst_idle_pct = 57;
    int quiet_cycles = 0;
    int frees_sent = 0;
    localparam int QUIET_LIMIT = 20000;

    buddy_block_allocator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_request(s_data);
            if (m_valid && m_ready) board.check_response(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog expired");
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= dst_idle_pct);

    task automatic send_beat(bba_pkg::req_t q);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data  <= q;
        s_valid <= 1'b1;
        #1;
        while (!s_ready) begin
            @(negedge aclk);
            #1;
        end
        @(posedge aclk);
        @(negedge aclk);
        if (q.req_type == bba_pkg::REQ_FREE) frees_sent++;
    endtask

    task automatic send_alloc(bit [31:0] bytes);
        bba_pkg::req_t q;
        q = '0;
        q.req_type = bba_pkg::REQ_ALLOC;
        q.request_bytes = bytes;
        q.block_offset = 7'($urandom);
        send_beat(q);
    endtask

    task automatic send_free(bit [6:0] off);
        bba_pkg::req_t q;
        q = '0;
        q.req_type = bba_pkg::REQ_FREE;
        q.block_offset = off;
        q.request_bytes = $urandom;
        send_beat(q);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
    endtask

    task automatic random_phase(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 45) begin
                case ($urandom_range(3))
                    0: send_alloc($urandom_range(4096));
                    1: send_alloc($urandom_range(65536));
                    2: send_alloc($urandom_range(1 << 19));
                    default: send_alloc($urandom);
                endcase
            end else if (k < 90) begin
                send_free(board.some_live_block());
            end else begin
                send_free(7'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_alloc(32'd0);
        send_alloc(32'd1);
        send_alloc(32'd4096);
        send_alloc(32'd4097);
        send_alloc(32'd524288);
        send_alloc(32'd524289);
        send_alloc(32'hFFFF_FFFF);
        send_free(7'd0);
        send_free(7'd0);
        send_free(7'd1);
        send_free(7'd2);
        send_free(7'd127);
        send_alloc(32'd524288);
        send_alloc(32'd1);
        send_free(7'd0);
        send_free(7'd0);
        send_alloc(32'd8192);
        send_alloc(32'd4096);
        send_free(7'd0);
        send_free(7'd2);
        drain();
        random_phase(200);
        drain();
        src_idle_pct = 57;
        dst_idle_pct = 19;
        random_phase(200);
        drain();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        random_phase(200);
        drain();
        repeat (300) @(posedge aclk);
        $display("covered %0d responses: %0d grants, %0d frees, %0d merge steps",
                 board.checked, board.allocs_ok, frees_sent, board.merges);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches, %0d left waiting", board.mismatches,
                     board.pending.size());
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
